// File: rtl/core/hrt_pkg.sv
`default_nettype none

package hrt_pkg;

   localparam int unsigned STORE_DEPTH_DEFAULT = 8192;
   localparam int unsigned RATE_MAX            = 220;
   localparam int unsigned TIMEOUT_RESET       = 5000;

   localparam int unsigned FUNC_W    = 3;
   localparam int unsigned BPM_W     = 8;
   localparam int unsigned INDEX_W   = 13;
   localparam int unsigned COUNT_W   = 14;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned TIMEOUT_W = 16;

   localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SAMPLE = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_START  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_READ   = 3'd5;

   typedef struct packed {
      logic [BPM_W-1:0]  bpm;
      logic [TIME_W-1:0] time_ms;
   } sample_type;

endpackage

`default_nettype wire

// File: rtl/core/hrt_if.sv
`default_nettype none

interface hrt_req_if
   import hrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic [FUNC_W-1:0]  func;
   logic [BPM_W-1:0]   bpm;
   logic [INDEX_W-1:0] sample_index;

   modport source (output valid, func, bpm, sample_index, input ready);
   modport sink   (input valid, func, bpm, sample_index, output ready);
endinterface

interface hrt_rsp_if
   import hrt_pkg::*;
   ();
   logic               valid;
   logic               ready;
   logic               status;
   logic [BPM_W-1:0]   current_hr;
   logic               hr_valid;
   logic [BPM_W-1:0]   avg_hr;
   logic [BPM_W-1:0]   max_hr;
   logic [COUNT_W-1:0] rec_total;
   logic               read_ok;
   logic [BPM_W-1:0]   read_bpm;
   logic [TIME_W-1:0]  read_time_ms;

   modport source (output valid, status, current_hr, hr_valid, avg_hr, max_hr,
                   rec_total, read_ok, read_bpm, read_time_ms, input ready);
   modport sink   (input valid, status, current_hr, hr_valid, avg_hr, max_hr,
                   rec_total, read_ok, read_bpm, read_time_ms, output ready);
endinterface

interface hrt_csr_if
   import hrt_pkg::*;
   ();
   logic                 valid;
   logic                 ready;
   logic [TIMEOUT_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/heart_rate_tracker_unit.sv
// channel   | role  | handshake     | carries
// req_bus   | sink  | valid / ready | func, bpm, sample_index
// rsp_bus   | source| valid / ready | status, rates, count, read-back sample
// csr_bus   | sink  | valid / ready | stale timeout in ms, always ready
//
// one item goes through accept, the load state, SW steps of the divider for the
// average (SW = sum width), a done step and the output state, which waits for a free output register
// reset is synchronous; the sample store has no reset and is read only below the count
// req_ready is low while an item is in flight; a result waits in the output
// register and the next item is taken while it waits
`default_nettype none

module heart_rate_tracker_unit
   import hrt_pkg::*;
#(
   parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   hrt_req_if.sink   req_bus,
   hrt_rsp_if.source rsp_bus,
   hrt_csr_if.sink   csr_bus
);

   localparam int unsigned AW = $clog2(STORE_DEPTH);
   localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
   localparam int unsigned SW = $clog2(STORE_DEPTH * RATE_MAX + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOAD = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    last_ff;
   logic                 have_ff;
   logic [BPM_W-1:0]     latest_ff;
   logic                 rec_ff;
   logic [CW-1:0]        count_ff;
   logic [SW-1:0]        sum_ff;
   logic [BPM_W-1:0]     peak_ff;

   logic                 status_ff;
   logic                 rd_ok_ff;
   logic [BPM_W-1:0]     cur_ff;
   logic                 valid_ff;
   logic [BPM_W-1:0]     rbpm_ff;
   logic [TIME_W-1:0]    rtime_ff;

   logic                 rsp_valid_ff;
   logic                 o_status_ff;
   logic [BPM_W-1:0]     o_cur_ff;
   logic                 o_valid_ff;
   logic [BPM_W-1:0]     o_avg_ff;
   logic [BPM_W-1:0]     o_max_ff;
   logic [COUNT_W-1:0]   o_count_ff;
   logic                 o_rok_ff;
   logic [BPM_W-1:0]     o_rbpm_ff;
   logic [TIME_W-1:0]    o_rtime_ff;

   logic                 accept;
   logic                 bpm_bad;
   logic                 room;
   logic                 do_write;
   logic [TIME_W-1:0]    idx_wide;
   logic                 rd_hit;
   logic                 do_read;
   logic [TIME_W-1:0]    age;
   logic                 div_start;
   logic                 div_done;
   logic [BPM_W-1:0]     div_quo;
   logic                 load_out;
   sample_type           wr_sample;
   sample_type           rd_sample;

   assign accept   = req_bus.valid && (state_ff == S_IDLE);
   assign bpm_bad  = (req_bus.bpm == '0) || (req_bus.bpm > BPM_W'(RATE_MAX));
   assign room     = count_ff < CW'(STORE_DEPTH);
   assign do_write = accept && (req_bus.func == FUNC_SAMPLE) && !bpm_bad && rec_ff && room;
   assign idx_wide = TIME_W'(req_bus.sample_index);
   assign rd_hit   = (idx_wide < TIME_W'(count_ff)) && (idx_wide < TIME_W'(STORE_DEPTH));
   assign do_read  = accept && (req_bus.func == FUNC_READ) && rd_hit;
   assign age      = now_ff - last_ff;
   assign div_start = (state_ff == S_LOAD);
   assign load_out = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_bus.ready);

   assign wr_sample.bpm     = req_bus.bpm;
   assign wr_sample.time_ms = now_ff;

   hrt_store #(
      .DEPTH (STORE_DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (wr_sample),
      .rd_en   (do_read),
      .rd_addr (idx_wide[AW-1:0]),
      .rd_data (rd_sample)
   );

   hrt_divider #(
      .SW (SW),
      .CW (CW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_ff),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_LOAD;
         end
         S_LOAD: state_in = S_DIV;
         S_DIV: begin
            if (div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (load_out) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         timeout_ff <= TIMEOUT_W'(TIMEOUT_RESET);
         now_ff     <= '0;
         last_ff    <= '0;
         have_ff    <= 1'b0;
         latest_ff  <= '0;
         rec_ff     <= 1'b0;
         count_ff   <= '0;
         sum_ff     <= '0;
         peak_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_bus.valid) begin
            timeout_ff <= csr_bus.data;
         end
         if (accept) begin
            unique case (req_bus.func)
               FUNC_TICK: now_ff <= now_ff + TIME_W'(1);
               FUNC_SAMPLE: begin
                  if (!bpm_bad) begin
                     latest_ff <= req_bus.bpm;
                     last_ff   <= now_ff;
                     have_ff   <= 1'b1;
                     if (rec_ff && room) begin
                        count_ff <= count_ff + CW'(1);
                        sum_ff   <= sum_ff + SW'(req_bus.bpm);
                        if (req_bus.bpm > peak_ff) peak_ff <= req_bus.bpm;
                     end
                  end
               end
               FUNC_START: begin
                  rec_ff   <= 1'b1;
                  count_ff <= '0;
                  sum_ff   <= '0;
                  peak_ff  <= '0;
               end
               FUNC_STOP: rec_ff <= 1'b0;
               FUNC_CLEAR: begin
                  count_ff <= '0;
                  sum_ff   <= '0;
                  peak_ff  <= '0;
               end
               default: begin
               end
            endcase
         end
      end
   end

   // per-item result fields: status and read hit at accept, the rest in the load state once the state has settled
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= (req_bus.func == FUNC_SAMPLE) && bpm_bad;
         rd_ok_ff  <= (req_bus.func == FUNC_READ) && rd_hit;
      end
      if (state_ff == S_LOAD) begin
         valid_ff <= have_ff && (age < TIME_W'(timeout_ff));
         cur_ff   <= (have_ff && (age < TIME_W'(timeout_ff))) ? latest_ff : '0;
         rbpm_ff  <= rd_ok_ff ? rd_sample.bpm : '0;
         rtime_ff <= rd_ok_ff ? rd_sample.time_ms : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         o_status_ff <= status_ff;
         o_cur_ff    <= cur_ff;
         o_valid_ff  <= valid_ff;
         o_avg_ff    <= div_quo;
         o_max_ff    <= peak_ff;
         o_count_ff  <= COUNT_W'(count_ff);
         o_rok_ff    <= rd_ok_ff;
         o_rbpm_ff   <= rbpm_ff;
         o_rtime_ff  <= rtime_ff;
      end
   end

   assign req_bus.ready = (state_ff == S_IDLE);
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = o_status_ff;
   assign rsp_bus.current_hr   = o_cur_ff;
   assign rsp_bus.hr_valid     = o_valid_ff;
   assign rsp_bus.avg_hr       = o_avg_ff;
   assign rsp_bus.max_hr       = o_max_ff;
   assign rsp_bus.rec_total    = o_count_ff;
   assign rsp_bus.read_ok      = o_rok_ff;
   assign rsp_bus.read_bpm     = o_rbpm_ff;
   assign rsp_bus.read_time_ms = o_rtime_ff;

endmodule

`default_nettype wire

// File: rtl/core/hrt_divider.sv
`default_nettype none

module hrt_divider
   import hrt_pkg::*;
#(
   parameter int unsigned SW = 21,
   parameter int unsigned CW = 14
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [SW-1:0] dividend,
   input  wire logic [CW-1:0] divisor,
   output logic               done,
   output logic [BPM_W-1:0]   quotient
);

   localparam int unsigned NW = $clog2(SW + 1);

   logic          busy_ff;
   logic          done_ff;
   logic [NW-1:0] cnt_ff;
   logic [SW-1:0] quo_ff;
   logic [CW-1:0] rem_ff;
   logic [CW-1:0] div_ff;
   logic          zero_ff;

   logic [CW:0]   trial;
   logic [CW:0]   diff;
   logic          ge;
   logic [CW-1:0] rem_in;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial  = {rem_ff, quo_ff[SW-1]};
      diff   = trial - {1'b0, div_ff};
      ge     = trial >= {1'b0, div_ff};
      rem_in = ge ? diff[CW-1:0] : trial[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= NW'(SW);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - NW'(1);
            if (cnt_ff == NW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SW-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff[BPM_W-1:0];

endmodule

`default_nettype wire

// File: rtl/core/hrt_store.sv
`default_nettype none

module hrt_store
   import hrt_pkg::*;
#(
   parameter int unsigned DEPTH = STORE_DEPTH_DEFAULT,
   parameter int unsigned AW    = $clog2(DEPTH)
) (
   input  wire logic       clock,
   input  wire logic       wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire sample_type wr_data,
   input  wire logic       rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output sample_type      rd_data
);

   sample_type mem [DEPTH];
   sample_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: dv/hrt_result_check.sv
`timescale 1ns / 100ps

module hrt_result_check
   import hrt_pkg::*;
#(
   parameter int unsigned DEPTH = STORE_DEPTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   hrt_req_if        req_bus,
   hrt_rsp_if        rsp_bus,
   hrt_csr_if        csr_bus,
   output int        fail_count,
   output int        pending_rsp,
   output int        checked_rsp
);

   typedef struct packed {
      logic               status;
      logic [BPM_W-1:0]   current_hr;
      logic               hr_valid;
      logic [BPM_W-1:0]   avg_hr;
      logic [BPM_W-1:0]   max_hr;
      logic [COUNT_W-1:0] rec_total;
      logic               read_ok;
      logic [BPM_W-1:0]   read_bpm;
      logic [TIME_W-1:0]  read_time_ms;
   } tracker_rsp_type;

   tracker_rsp_type      predicted_rsp[$];

   logic [TIME_W-1:0]    now_ms;
   logic [TIME_W-1:0]    rate_ms;
   logic                 rate_seen;
   logic [BPM_W-1:0]     rate_bpm;
   logic                 recording;
   int unsigned          rec_count;
   logic [20:0]          bpm_sum;
   logic [BPM_W-1:0]     peak_bpm;
   logic [TIMEOUT_W-1:0] stale_ms;
   sample_type           sample_log[DEPTH];

   initial begin
      fail_count  = 0;
      pending_rsp = 0;
      checked_rsp = 0;
   end

   function automatic void clear_log();
      rec_count = 0;
      bpm_sum   = '0;
      peak_bpm  = '0;
   endfunction

   function automatic tracker_rsp_type predict_tracker_rsp(input logic [FUNC_W-1:0]  f,
                                                           input logic [BPM_W-1:0]   b,
                                                           input logic [INDEX_W-1:0] ix);
      tracker_rsp_type   r;
      logic [TIME_W-1:0] age;
      r = '0;
      case (f)
         FUNC_TICK: now_ms = now_ms + 1'b1;
         FUNC_SAMPLE: begin
            if (b == 0 || b > RATE_MAX) begin
               r.status = 1'b1;
            end else begin
               rate_bpm  = b;
               rate_ms   = now_ms;
               rate_seen = 1'b1;
               // once the store is full only the current rate moves
               if (recording && rec_count < DEPTH) begin
                  sample_log[rec_count].bpm     = b;
                  sample_log[rec_count].time_ms = now_ms;
                  rec_count++;
                  bpm_sum = bpm_sum + b;
                  if (b > peak_bpm) peak_bpm = b;
               end
            end
         end
         FUNC_START: begin
            clear_log();
            recording = 1'b1;
         end
         FUNC_STOP:  recording = 1'b0;
         FUNC_CLEAR: clear_log();
         FUNC_READ: begin
            if (ix < rec_count) begin
               r.read_ok      = 1'b1;
               r.read_bpm     = sample_log[ix].bpm;
               r.read_time_ms = sample_log[ix].time_ms;
            end
         end
         default: ;
      endcase
      // age wraps modulo 2^32
      age = now_ms - rate_ms;
      if (rate_seen && age < {16'b0, stale_ms}) begin
         r.hr_valid   = 1'b1;
         r.current_hr = rate_bpm;
      end
      if (rec_count != 0) r.avg_hr = BPM_W'(bpm_sum / rec_count);
      r.max_hr    = peak_bpm;
      r.rec_total = COUNT_W'(rec_count);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      fail_count++;
      $display("[%0t] tracker mismatch at result %0d: %s", $time, checked_rsp, what);
   endtask

   task automatic check_field(input string field, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", field, got, want));
      end
   endtask

   always @(posedge clock) begin
      tracker_rsp_type want;
      if (reset) begin
         now_ms    = '0;
         rate_ms   = '0;
         rate_seen = 1'b0;
         rate_bpm  = '0;
         recording = 1'b0;
         stale_ms  = TIMEOUT_W'(TIMEOUT_RESET);
         clear_log();
         predicted_rsp.delete();
      end else begin
         if (csr_bus.valid && csr_bus.ready) stale_ms = csr_bus.data;
         if (req_bus.valid && req_bus.ready) begin
            predicted_rsp.push_back(predict_tracker_rsp(req_bus.func, req_bus.bpm,
                                                        req_bus.sample_index));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_rsp.size() == 0) begin
               report_mismatch("result item with no command outstanding");
            end else begin
               want = predicted_rsp.pop_front();
               check_field("status", rsp_bus.status, want.status);
               check_field("current_hr", rsp_bus.current_hr, want.current_hr);
               check_field("hr_valid", rsp_bus.hr_valid, want.hr_valid);
               check_field("avg_hr", rsp_bus.avg_hr, want.avg_hr);
               check_field("max_hr", rsp_bus.max_hr, want.max_hr);
               check_field("rec_total", rsp_bus.rec_total, want.rec_total);
               check_field("read_ok", rsp_bus.read_ok, want.read_ok);
               check_field("read_bpm", rsp_bus.read_bpm, want.read_bpm);
               check_field("read_time_ms", rsp_bus.read_time_ms, want.read_time_ms);
            end
            checked_rsp++;
         end
      end
      pending_rsp = predicted_rsp.size();
   end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import hrt_pkg::*;

   // codes the block ignores
   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int fail_count;
   int pending_rsp;
   int checked_rsp;
   int commands_sent = 0;
   bit req_gaps      = 1'b1;
   bit rsp_gaps      = 1'b1;
   bit long_hold     = 1'b0;
   logic [TIMEOUT_W-1:0] mid_timeout;

   hrt_req_if req_bus ();
   hrt_rsp_if rsp_bus ();
   hrt_csr_if csr_bus ();

   heart_rate_tracker_unit u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   hrt_result_check u_check (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus),
      .fail_count  (fail_count),
      .pending_rsp (pending_rsp),
      .checked_rsp (checked_rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_rsp);
      $display("Simulation FAILED");
      $finish;
   end

   // result side: random back-pressure, plus one long hold on request
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_bus.ready <= 1'b0;
            repeat (400) @(negedge clock);
            long_hold = 1'b0;
         end else if (rsp_gaps && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
      end
   end

   // called and left at a falling edge
   task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic [BPM_W-1:0] b,
                           input logic [INDEX_W-1:0] ix);
      if (req_gaps && $urandom_range(0, 4) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.func         <= f;
      req_bus.bpm          <= b;
      req_bus.sample_index <= ix;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      commands_sent++;
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_rsp != 0) @(negedge clock);
   endtask

   task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= v;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // mostly ticks and in-range samples, as a live sensor would give
   task automatic random_cmd(input bit allow_restart, input int unsigned idx_hi);
      int unsigned         pick;
      logic [FUNC_W-1:0]   f;
      logic [BPM_W-1:0]    b;
      logic [INDEX_W-1:0]  ix;
      pick = $urandom_range(0, 99);
      b    = ($urandom_range(0, 4) == 0) ? BPM_W'($urandom_range(0, 255))
                                         : BPM_W'($urandom_range(1, RATE_MAX));
      ix   = ($urandom_range(0, 3) == 0) ? INDEX_W'($urandom)
                                         : INDEX_W'($urandom_range(0, idx_hi));
      if (pick < 45)                       f = FUNC_TICK;
      else if (pick < 75)                  f = FUNC_SAMPLE;
      else if (pick < 77 && allow_restart) f = FUNC_START;
      else if (pick < 80)                  f = FUNC_STOP;
      else if (pick < 82 && allow_restart) f = FUNC_CLEAR;
      else if (pick < 97)                  f = FUNC_READ;
      else if (pick < 98)                  f = FUNC_START;
      else                                 f = $urandom_range(0, 1) ? FUNC_SPARE_A
                                                                    : FUNC_SPARE_B;
      // with restarts barred the recorded store must survive
      if (!allow_restart && f == FUNC_START) f = FUNC_TICK;
      send_cmd(f, b, ix);
   endtask

   initial begin
      req_bus.valid        = 1'b0;
      req_bus.func         = FUNC_TICK;
      req_bus.bpm          = '0;
      req_bus.sample_index = '0;
      csr_bus.valid        = 1'b0;
      csr_bus.data         = '0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty store, ignored codes, rejects, restart, stop and clear
      send_cmd(FUNC_READ, 8'd0, 13'd0);
      send_cmd(FUNC_SPARE_A, 8'hFF, 13'h1FFF);
      send_cmd(FUNC_SPARE_B, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd221, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd255, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd220, 13'd0);
      send_cmd(FUNC_TICK, 8'd0, 13'd0);
      send_cmd(FUNC_START, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd1, 13'd0);
      send_cmd(FUNC_TICK, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd220, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd128, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd2);
      send_cmd(FUNC_READ, 8'd0, 13'd3);
      send_cmd(FUNC_READ, 8'd0, 13'h1FFF);
      send_cmd(FUNC_START, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd100, 13'd0);
      send_cmd(FUNC_STOP, 8'd0, 13'd0);
      send_cmd(FUNC_SAMPLE, 8'd50, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd1);
      send_cmd(FUNC_CLEAR, 8'd0, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd0);

      wait_drained();
      write_timeout(16'd3);
      repeat (250) random_cmd(1'b1, 40);

      // zero timeout: the rate is never fresh
      wait_drained();
      write_timeout(16'd0);
      repeat (100) random_cmd(1'b1, 40);

      // record a run of samples, then read across it
      wait_drained();
      write_timeout(16'hFFFF);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      send_cmd(FUNC_START, 8'd0, 13'd0);
      for (int n = 0; n < 200; n++) begin
         if (n % 8 == 0) send_cmd(FUNC_TICK, 8'd0, 13'd0);
         send_cmd(FUNC_SAMPLE, BPM_W'($urandom_range(1, RATE_MAX)), 13'd0);
      end
      send_cmd(FUNC_READ, 8'd0, 13'd0);
      send_cmd(FUNC_READ, 8'd0, 13'd199);
      send_cmd(FUNC_READ, 8'd0, 13'h1FFF);
      req_gaps = 1'b1;
      rsp_gaps = 1'b1;
      repeat (200) random_cmd(1'b0, 255);

      // long result stall while commands keep coming, then a full pause
      wait_drained();
      mid_timeout = TIMEOUT_W'($urandom_range(10, 40));
      write_timeout(mid_timeout);
      long_hold = 1'b1;
      repeat (12) random_cmd(1'b1, 40);
      wait_drained();
      repeat (250) random_cmd(1'b1, 40);

      // last stretch flat out
      wait_drained();
      write_timeout(16'd1);
      req_gaps = 1'b0;
      rsp_gaps = 1'b0;
      repeat (280) random_cmd(1'b1, 40);

      wait_drained();
      repeat (40) @(negedge clock);

      $display("sent %0d commands and checked %0d results, including a 200 sample recording",
               commands_sent, checked_rsp);
      $display("stale timeouts covered: 5000 after reset, 3, 0, 65535, %0d and 1 ms",
               mid_timeout);
      if (fail_count == 0 && pending_rsp == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches, %0d results never seen", fail_count, pending_rsp);
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
